>>> sv/mfr_pkg.sv
// Package for the marker frame receiver: widths, store depth, register indexes,
// controller state type and the command/status structs shared by controller,
// datapath and top level. No dependencies.
package mfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
    localparam int LEN_W        = 7;
    localparam int CFG_IDX_W    = 2;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd42;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd35;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_FRAME,
        ST_READ,
        ST_EMIT,
        ST_OVF
    } state_t;

    typedef struct packed {
        logic start_frame;
        logic store_byte;
        logic clear_fill;
        logic rd_start;
        logic rd_issue;
        logic rd_advance;
        logic sel_ovf;
    } cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_full;
        logic closes;
        logic is_last;
    } status_t;

endpackage

>>> sv/mfr_if.sv
// Channel interfaces of the marker frame receiver: received bytes, frame
// results and register writes. Depends on mfr_pkg.
interface mfr_in_if;
    logic                        valid;
    logic                        ready;
    logic [mfr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfr_out_if;
    logic                        valid;
    logic                        ready;
    logic [mfr_pkg::BYTE_W-1:0]  frame_byte;
    logic                        frame_last;
    logic [mfr_pkg::LEN_W-1:0]   frame_length;
    logic                        overflow;

    modport source (output valid, output frame_byte, output frame_last,
                    output frame_length, output overflow, input ready);
    modport sink   (input valid, input frame_byte, input frame_last,
                    input frame_length, input overflow, output ready);
endinterface

interface mfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mfr_pkg::CFG_IDX_W-1:0] index;
    logic [mfr_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mfr_ctrl.sv
// Controller state machine of the marker frame receiver: hunt, collect,
// read out and overflow report. Depends on mfr_pkg.
module mfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mfr_pkg::status_t  status,
    output mfr_pkg::cmd_t     cmd
);
    import mfr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_valid && status.is_start)
                begin
                    state_next = ST_FRAME;
                end
            end
            ST_FRAME:
            begin
                if (in_valid)
                begin
                    if (status.is_full)
                    begin
                        state_next = ST_OVF;
                    end
                    else if (status.closes)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = status.is_last ? ST_HUNT : ST_READ;
                end
            end
            ST_OVF:
            begin
                if (out_ready)
                begin
                    state_next = ST_HUNT;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                in_ready        = 1'b1;
                cmd.start_frame = in_valid && status.is_start;
            end
            ST_FRAME:
            begin
                in_ready       = 1'b1;
                cmd.clear_fill = in_valid && status.is_full;
                cmd.store_byte = in_valid && !status.is_full;
                cmd.rd_start   = in_valid && !status.is_full && status.closes;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid      = 1'b1;
                cmd.clear_fill = out_ready && status.is_last;
                cmd.rd_advance = out_ready && !status.is_last;
            end
            ST_OVF:
            begin
                out_valid   = 1'b1;
                cmd.sel_ovf = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/mfr_dp.sv
// Datapath of the marker frame receiver: marker registers, frame store,
// fill count, previous byte and read pointer. Depends on mfr_pkg.
module mfr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfr_pkg::BYTE_W-1:0]    cfg_data,
    input  logic [mfr_pkg::BYTE_W-1:0]    rx_byte,
    input  mfr_pkg::cmd_t                 cmd,
    output mfr_pkg::status_t              status,
    output logic [mfr_pkg::BYTE_W-1:0]    frame_byte,
    output logic                          frame_last,
    output logic [mfr_pkg::LEN_W-1:0]     frame_length,
    output logic                          overflow
);
    import mfr_pkg::*;

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [BYTE_W-1:0] prev_reg;
    logic [BYTE_W-1:0] prev_next;
    logic [FILL_W-1:0] rd_ptr_reg;
    logic [FILL_W-1:0] rd_ptr_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] store_mem [BUFFER_DEPTH];
    logic [FILL_W-1:0] rd_ptr_inc;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_data;
                CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                default:          start_marker_reg <= start_marker_reg;
            endcase
        end
    end

    assign rd_ptr_inc = rd_ptr_reg + FILL_W'(1);

    assign status.is_start = (rx_byte == start_marker_reg);
    assign status.is_full  = (fill_reg == FILL_W'(BUFFER_DEPTH));
    assign status.closes   = (rx_byte == end_marker_reg) && (prev_reg == end_marker_reg);
    assign status.is_last  = (rd_ptr_inc == fill_reg);

    always_comb
    begin
        fill_next   = fill_reg;
        prev_next   = prev_reg;
        rd_ptr_next = rd_ptr_reg;
        if (cmd.start_frame)
        begin
            fill_next = FILL_W'(1);
            prev_next = rx_byte;
        end
        else if (cmd.store_byte)
        begin
            fill_next = fill_reg + FILL_W'(1);
            prev_next = rx_byte;
        end
        else if (cmd.clear_fill)
        begin
            fill_next = '0;
        end
        if (cmd.rd_start)
        begin
            rd_ptr_next = '0;
        end
        else if (cmd.rd_advance)
        begin
            rd_ptr_next = rd_ptr_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            prev_reg   <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            prev_reg   <= prev_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.start_frame)
        begin
            store_mem[0] <= rx_byte;
        end
        else if (cmd.store_byte)
        begin
            store_mem[fill_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_ptr_reg[ADDR_W-1:0]];
        end
    end

    assign frame_byte   = cmd.sel_ovf ? '0 : rd_data_reg;
    assign frame_last   = cmd.sel_ovf ? 1'b1 : status.is_last;
    assign frame_length = cmd.sel_ovf ? '0 : LEN_W'(fill_reg);
    assign overflow     = cmd.sel_ovf;

endmodule

>>> sv/marker_frame_receiver.sv
// Marker frame receiver top level: joins controller and datapath to the
// byte, result and register write channels. Depends on mfr_pkg, mfr_if,
// mfr_ctrl, mfr_dp. After the closing end marker is taken, ST_READ loads the
// store's registered read port and ST_EMIT offers the first result. One byte
// per cycle is taken while collecting; each result passes through ST_READ and
// ST_EMIT at the single read port, and the next is read only once the last
// is taken. No byte is taken while results are pending. Reset (rst_n low,
// async) returns to hunting with fill count zero and markers at 42 and 35.
module marker_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    mfr_in_if.sink      rx,
    mfr_out_if.source   frame,
    mfr_cfg_if.sink     cfg
);
    import mfr_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;
    logic    out_valid;

    // Markers are plain registers, so a write beat always completes at once.
    assign cfg.ready = 1'b1;

    // Controller: decide what each byte beat and each result beat does.
    mfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (frame.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: hold markers, collect the frame, walk the store on readout.
    mfr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .rx_byte      (rx.rx_byte),
        .cmd          (cmd),
        .status       (status),
        .frame_byte   (frame.frame_byte),
        .frame_last   (frame.frame_last),
        .frame_length (frame.frame_length),
        .overflow     (frame.overflow)
    );

    assign rx.ready    = in_ready;
    assign frame.valid = out_valid;

endmodule

>>> sv/mfr_checker.sv
// Port-level checker for the marker frame receiver, bound to the top level.
// Depends on mfr_pkg and marker_frame_receiver.
module mfr_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [mfr_pkg::BYTE_W-1:0]  frame_byte,
    input  logic                        frame_last,
    input  logic [mfr_pkg::LEN_W-1:0]   frame_length,
    input  logic                        overflow
);
    import mfr_pkg::*;

    // Hold a result until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // Take no byte while a result is pending.
    a_no_rx_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("byte taken while a result is pending");

    // Overflow report is a single zero result marked last.
    a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> frame_last && frame_byte == '0 && frame_length == '0)
        else $error("malformed overflow result");

    // A real frame holds at least both end markers and fits the store.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow |-> frame_length >= LEN_W'(2)
                                   && frame_length <= LEN_W'(BUFFER_DEPTH))
        else $error("frame length out of range");

    // After the last result of a run, the next result starts a new run.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && frame_last |=> !out_valid)
        else $error("result follows the last beat without a new frame");

endmodule

bind marker_frame_receiver mfr_checker u_mfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (rx.ready),
    .out_valid    (frame.valid),
    .out_ready    (frame.ready),
    .frame_byte   (frame.frame_byte),
    .frame_last   (frame.frame_last),
    .frame_length (frame.frame_length),
    .overflow     (frame.overflow)
);
